/* hdl/blcu_pkg.sv */
// Package for the byte lane compare unit: operation codes, word types and
// the lane control group. Depends on nothing; every other file uses it.
package blcu_pkg;

	localparam int unsigned MAX_LANES = 8;
	localparam int unsigned LANE_W    = 8;
	localparam int unsigned WORD_W    = MAX_LANES * LANE_W;
	localparam int unsigned OP_W      = 4;
	localparam int unsigned LRES_W    = 4;

	localparam logic [7:0] CASE_BIT   = 8'h20;
	localparam logic [7:0] CHAR_A_LO  = 8'h61;
	localparam logic [7:0] CHAR_Z_LO  = 8'h7A;
	localparam logic [7:0] HI_NIBBLE  = 8'hF0;
	localparam logic [7:0] DIGIT_BLK  = 8'h30;
	localparam logic [7:0] UPPER_MASK = 8'hE0;
	localparam logic [7:0] UPPER_BLK  = 8'h40;
	localparam logic [7:0] FLAG_BYTE  = 8'h80;
	localparam logic [7:0] LOW7_MASK  = 8'h7F;

	typedef enum logic [OP_W-1:0] {
		OP_GE      = 4'd0,
		OP_LE      = 4'd1,
		OP_SUB7    = 4'd2,
		OP_ZERO    = 4'd3,
		OP_EQ      = 4'd4,
		OP_XOR     = 4'd5,
		OP_FAM_EQ  = 4'd6,
		OP_UPPER   = 4'd7,
		OP_DIGIT   = 4'd8,
		OP_ALPHA   = 4'd9,
		OP_COUNT   = 4'd10,
		OP_LOWIDX  = 4'd11,
		OP_HIGHIDX = 4'd12,
		OP_LOWER   = 4'd13
	} blcu_op_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [WORD_W-1:0] data_word;
		logic [WORD_W-1:0] other_word;
		logic [7:0]        key_byte;
		logic [7:0]        family_bits;
		logic              ignore_case;
		logic [WORD_W-1:0] lane_mask;
	} blcu_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic [LRES_W-1:0] lane_result;
	} blcu_out_t;

	// Broadcast controls shared by every lane.
	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic [7:0]      key_byte;
		logic [7:0]      family_bits;
		logic            ignore_case;
	} blcu_lane_ctrl_t;

endpackage

/* hdl/blcu_lane.sv */
// One byte lane of the compare unit: every per-lane operation on one byte.
// Depends on blcu_pkg.
module blcu_lane (
	input  blcu_pkg::blcu_lane_ctrl_t ctrl,
	input  logic [7:0]                data_byte,
	input  logic [7:0]                other_byte,
	output logic [7:0]                res_byte
);

	logic [7:0] folded;
	logic       letter;
	logic [7:0] eq_diff;
	logic [7:0] xor_diff;
	logic [7:0] sub_diff;

	assign folded   = data_byte | blcu_pkg::CASE_BIT;
	assign letter   = (folded >= blcu_pkg::CHAR_A_LO) && (folded <= blcu_pkg::CHAR_Z_LO);
	assign sub_diff = data_byte - ctrl.key_byte;

	// Drop the case bit from the difference on letter lanes when folding.
	always_comb begin
		eq_diff  = data_byte ^ ctrl.key_byte;
		xor_diff = data_byte ^ other_byte;
		if (ctrl.ignore_case && letter) begin
			eq_diff  = eq_diff & ~blcu_pkg::CASE_BIT;
			xor_diff = xor_diff & ~blcu_pkg::CASE_BIT;
		end
	end

	always_comb begin
		unique case (blcu_pkg::blcu_op_t'(ctrl.opcode))
			blcu_pkg::OP_GE: begin
				res_byte = (data_byte >= ctrl.key_byte) ? blcu_pkg::FLAG_BYTE : 8'h00;
			end
			blcu_pkg::OP_LE: begin
				res_byte = (data_byte <= ctrl.key_byte) ? blcu_pkg::FLAG_BYTE : 8'h00;
			end
			blcu_pkg::OP_SUB7: begin
				res_byte = sub_diff & blcu_pkg::LOW7_MASK;
			end
			blcu_pkg::OP_ZERO: begin
				res_byte = (data_byte == 8'h00) ? blcu_pkg::FLAG_BYTE : 8'h00;
			end
			blcu_pkg::OP_EQ: begin
				res_byte = (eq_diff == 8'h00) ? blcu_pkg::FLAG_BYTE : 8'h00;
			end
			blcu_pkg::OP_XOR: begin
				res_byte = xor_diff;
			end
			blcu_pkg::OP_FAM_EQ: begin
				res_byte = ((data_byte & ctrl.family_bits) ==
					(ctrl.key_byte & ctrl.family_bits)) ? blcu_pkg::FLAG_BYTE : 8'h00;
			end
			blcu_pkg::OP_UPPER: begin
				res_byte = ((data_byte & blcu_pkg::UPPER_MASK) == blcu_pkg::UPPER_BLK) ?
					blcu_pkg::FLAG_BYTE : 8'h00;
			end
			blcu_pkg::OP_DIGIT: begin
				res_byte = ((data_byte & blcu_pkg::HI_NIBBLE) == blcu_pkg::DIGIT_BLK) ?
					blcu_pkg::FLAG_BYTE : 8'h00;
			end
			blcu_pkg::OP_ALPHA: begin
				res_byte = letter ? blcu_pkg::FLAG_BYTE : 8'h00;
			end
			blcu_pkg::OP_LOWER: begin
				res_byte = letter ? folded : data_byte;
			end
			default: begin
				res_byte = 8'h00;
			end
		endcase
	end

endmodule

/* hdl/blcu_merge.sv */
// Merging stage: counts and locates the registered lane flags and picks the
// result word. Depends on blcu_pkg.
module blcu_merge #(
	parameter int unsigned LANES = 8
) (
	input  logic [blcu_pkg::OP_W-1:0]      opcode,
	input  logic [blcu_pkg::MAX_LANES-1:0] flags,
	input  logic [blcu_pkg::WORD_W-1:0]    lane_word,
	output blcu_pkg::blcu_out_t            result
);

	logic [blcu_pkg::LRES_W-1:0] count;
	logic [blcu_pkg::LRES_W-1:0] low_idx;
	logic [blcu_pkg::LRES_W-1:0] high_idx;

	// Flags above the configured lane count arrive cleared.
	always_comb begin
		count    = '0;
		low_idx  = blcu_pkg::LRES_W'(LANES);
		high_idx = blcu_pkg::LRES_W'(LANES);
		for (int i = 0; i < int'(blcu_pkg::MAX_LANES); i++) begin
			count = count + blcu_pkg::LRES_W'(flags[i]);
			if (flags[i]) begin
				high_idx = blcu_pkg::LRES_W'(i);
			end
		end
		for (int j = int'(blcu_pkg::MAX_LANES) - 1; j >= 0; j--) begin
			if (flags[j]) begin
				low_idx = blcu_pkg::LRES_W'(j);
			end
		end
	end

	always_comb begin
		result.result_word = lane_word;
		result.lane_result = '0;
		case (blcu_pkg::blcu_op_t'(opcode))
			blcu_pkg::OP_COUNT: begin
				result.result_word = '0;
				result.lane_result = count;
			end
			blcu_pkg::OP_LOWIDX: begin
				result.result_word = '0;
				result.lane_result = low_idx;
			end
			blcu_pkg::OP_HIGHIDX: begin
				result.result_word = '0;
				result.lane_result = high_idx;
			end
			default: begin
				result.result_word = lane_word;
			end
		endcase
	end

endmodule

/* hdl/byte_lane_compare_unit_top.sv */
// Top level of the byte lane compare unit: lane array, stage registers and
// output register. Depends on blcu_pkg, blcu_lane and blcu_merge.
//
//   channel   direction  handshake                    word type
//   item      in         item_valid / item_ready      blcu_pkg::blcu_in_t
//   result    out        result_valid / result_ready  blcu_pkg::blcu_out_t
//
// A word's result turns valid after the stage 1 register (lane results) and then the
// stage 2 register (merged result); one word is taken every cycle while results drain.
// Stage 1 holds the per-lane bytes and mask flags, stage 2 the merged result.
// A stalled result holds in stage 2 while an empty stage 1 still takes one more word.
// arst_n clears only the valid flags; payload registers carry no reset.
module byte_lane_compare_unit_top #(
	parameter int unsigned LANES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  blcu_pkg::blcu_in_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output blcu_pkg::blcu_out_t  result
);

	localparam int unsigned LW = blcu_pkg::LANE_W;

	blcu_pkg::blcu_lane_ctrl_t          ctrl;
	logic [blcu_pkg::WORD_W-1:0]        lane_word;
	logic [blcu_pkg::MAX_LANES-1:0]     lane_flags;

	logic                               valid_s1;
	logic [blcu_pkg::OP_W-1:0]          op_s1;
	logic [blcu_pkg::WORD_W-1:0]        word_s1;
	logic [blcu_pkg::MAX_LANES-1:0]     flags_s1;

	logic                               valid_s2;
	logic [blcu_pkg::OP_W-1:0]          op_s2;
	blcu_pkg::blcu_out_t                result_s2;
	blcu_pkg::blcu_out_t                merged;

	logic                               adv_s2;
	logic                               adv_s1;

	// Advance stage 2 when it is empty or its word leaves this cycle.
	assign adv_s2     = !valid_s2 || result_ready;
	// Take a new word when stage 1 is empty or moves on.
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item_ready = adv_s1;

	assign ctrl.opcode      = item.opcode;
	assign ctrl.key_byte    = item.key_byte;
	assign ctrl.family_bits = item.family_bits;
	assign ctrl.ignore_case = item.ignore_case;

	// Lane array: live lanes compute, lanes beyond LANES read as zero.
	for (genvar g = 0; g < int'(blcu_pkg::MAX_LANES); g++) begin : g_lane
		if (g < int'(LANES)) begin : g_live
			blcu_lane u_lane (
				.ctrl       (ctrl),
				.data_byte  (item.data_word[g*LW +: LW]),
				.other_byte (item.other_word[g*LW +: LW]),
				.res_byte   (lane_word[g*LW +: LW])
			);
			assign lane_flags[g] = item.lane_mask[g*LW + LW - 1];
		end else begin : g_dead
			assign lane_word[g*LW +: LW] = '0;
			assign lane_flags[g]         = 1'b0;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item_valid;
		end
	end

	// Stage 1 payload: load only on an accepted word.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_s1    <= item.opcode;
			word_s1  <= lane_word;
			flags_s1 <= lane_flags;
		end
	end

	blcu_merge #(
		.LANES (LANES)
	) u_merge (
		.opcode    (op_s1),
		.flags     (flags_s1),
		.lane_word (word_s1),
		.result    (merged)
	);

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload: hold while the consumer stalls.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= merged;
			op_s2     <= op_s1;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef NO_ASSERTIONS
	// An accepted word must occupy stage 1 on the next edge.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> valid_s1)
		else $error("accepted word lost before stage 1");

	// Stage 1 must hold its word while stage 2 is blocked.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(word_s1) && $stable(op_s1)))
		else $error("stage 1 word changed under stall");

	// Index and count operations deliver a zero word.
	a_idx_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (op_s2 == blcu_pkg::OP_COUNT || op_s2 == blcu_pkg::OP_LOWIDX ||
			op_s2 == blcu_pkg::OP_HIGHIDX)) |-> (result.result_word == '0))
		else $error("non-zero word on a mask operation");

	// Lane result never exceeds the lane count.
	a_lres_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.lane_result <= blcu_pkg::LRES_W'(LANES)))
		else $error("lane result out of range");

	// Word operations deliver a zero lane result.
	a_word_lres_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && op_s2 != blcu_pkg::OP_COUNT && op_s2 != blcu_pkg::OP_LOWIDX &&
			op_s2 != blcu_pkg::OP_HIGHIDX) |-> (result.lane_result == '0))
		else $error("lane result set on a word operation");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for byte_lane_compare_unit_top: directed and random
// words through both valid/ready channels, checked against a lane-wise model.
// Depends on blcu_pkg and the RTL of the unit; reads nothing else.
module tb;

	localparam int unsigned LANES = 8;

	// Opcodes beyond the defined set; the unit must answer them with zeros.
	localparam logic [blcu_pkg::OP_W-1:0] OP_SPARE_LO = 4'd14;
	localparam logic [blcu_pkg::OP_W-1:0] OP_SPARE_HI = 4'd15;

	localparam int RANDOM_WORDS   = 550;
	localparam int TAIL_WORDS     = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	blcu_pkg::blcu_in_t  item         = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	blcu_pkg::blcu_out_t result;

	blcu_pkg::blcu_in_t  pending_words[$];
	blcu_pkg::blcu_out_t expected_results[$];

	int mismatch_count = 0;
	int words_taken    = 0;
	int total_words    = 0;
	int send_gap       = 0;
	int recv_stall     = 0;
	int idle_cycles    = 0;

	byte_lane_compare_unit_top #(
		.LANES(LANES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// Free-running clock, period 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ASCII letter test after folding to lower case.
	function automatic logic is_letter(logic [7:0] b);
		logic [7:0] lo;
		lo = b | blcu_pkg::CASE_BIT;
		return (lo >= blcu_pkg::CHAR_A_LO) && (lo <= blcu_pkg::CHAR_Z_LO);
	endfunction

	// Work out the expected result word and lane result of one input word, lane by lane.
	function automatic blcu_pkg::blcu_out_t predict_lanes(blcu_pkg::blcu_in_t w);
		blcu_pkg::blcu_out_t r;
		logic [7:0]          b, o, x, lane;
		logic [3:0]          cnt, lo_idx, hi_idx;
		int                  i;
		r      = '0;
		cnt    = '0;
		lo_idx = 4'(LANES);
		hi_idx = 4'(LANES);
		for (i = 0; i < LANES; i++) begin
			b    = w.data_word[i*blcu_pkg::LANE_W +: blcu_pkg::LANE_W];
			o    = w.other_word[i*blcu_pkg::LANE_W +: blcu_pkg::LANE_W];
			lane = '0;
			case (w.opcode)
				blcu_pkg::OP_GE:
					lane = (b >= w.key_byte) ? blcu_pkg::FLAG_BYTE : 8'h00;
				blcu_pkg::OP_LE:
					lane = (b <= w.key_byte) ? blcu_pkg::FLAG_BYTE : 8'h00;
				blcu_pkg::OP_SUB7:
					lane = (b - w.key_byte) & blcu_pkg::LOW7_MASK;
				blcu_pkg::OP_ZERO:
					lane = (b == 8'h00) ? blcu_pkg::FLAG_BYTE : 8'h00;
				blcu_pkg::OP_EQ: begin
					x = b ^ w.key_byte;
					if (w.ignore_case && is_letter(b))
						x = x & ~blcu_pkg::CASE_BIT;
					lane = (x == 8'h00) ? blcu_pkg::FLAG_BYTE : 8'h00;
				end
				blcu_pkg::OP_XOR: begin
					x = b ^ o;
					if (w.ignore_case && is_letter(b))
						x = x & ~blcu_pkg::CASE_BIT;
					lane = x;
				end
				blcu_pkg::OP_FAM_EQ:
					lane = ((b & w.family_bits) == (w.key_byte & w.family_bits))
						? blcu_pkg::FLAG_BYTE : 8'h00;
				blcu_pkg::OP_UPPER:
					lane = ((b & blcu_pkg::UPPER_MASK) == blcu_pkg::UPPER_BLK)
						? blcu_pkg::FLAG_BYTE : 8'h00;
				blcu_pkg::OP_DIGIT:
					lane = ((b & blcu_pkg::HI_NIBBLE) == blcu_pkg::DIGIT_BLK)
						? blcu_pkg::FLAG_BYTE : 8'h00;
				blcu_pkg::OP_ALPHA:
					lane = is_letter(b) ? blcu_pkg::FLAG_BYTE : 8'h00;
				blcu_pkg::OP_LOWER:
					lane = is_letter(b) ? (b | blcu_pkg::CASE_BIT) : b;
				default:
					lane = 8'h00;
			endcase
			r.result_word[i*blcu_pkg::LANE_W +: blcu_pkg::LANE_W] = lane;
			if (w.lane_mask[i*blcu_pkg::LANE_W + 7]) begin
				cnt = cnt + 4'd1;
				if (lo_idx == 4'(LANES))
					lo_idx = 4'(i);
				hi_idx = 4'(i);
			end
		end
		case (w.opcode)
			blcu_pkg::OP_COUNT:   r.lane_result = cnt;
			blcu_pkg::OP_LOWIDX:  r.lane_result = lo_idx;
			blcu_pkg::OP_HIGHIDX: r.lane_result = hi_idx;
			default:              r.lane_result = '0;
		endcase
		return r;
	endfunction

	function automatic blcu_pkg::blcu_in_t make_item(logic [blcu_pkg::OP_W-1:0] op,
			logic [blcu_pkg::WORD_W-1:0] data, logic [blcu_pkg::WORD_W-1:0] other,
			logic [7:0] key, logic [7:0] fam, logic ci,
			logic [blcu_pkg::WORD_W-1:0] mask);
		blcu_pkg::blcu_in_t w;
		w.opcode      = op;
		w.data_word   = data;
		w.other_word  = other;
		w.key_byte    = key;
		w.family_bits = fam;
		w.ignore_case = ci;
		w.lane_mask   = mask;
		return w;
	endfunction

	// Text-like lane content: letters, class borders, the key and its case twin.
	function automatic logic [7:0] pick_lane_byte(logic [7:0] key);
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0:       b = 8'($urandom_range(8'h41, 8'h5A));
			1:       b = 8'($urandom_range(8'h61, 8'h7A));
			2:       b = key;
			3:       b = key ^ blcu_pkg::CASE_BIT;
			4:       b = 8'h00;
			5:       b = blcu_pkg::FLAG_BYTE | 8'($urandom);
			6:       b = blcu_pkg::DIGIT_BLK | 8'($urandom_range(0, 15));
			7:       b = blcu_pkg::UPPER_BLK | 8'($urandom_range(0, 31));
			8:       b = 8'($urandom);
			default: b = ($urandom_range(0, 1) ? 8'h60 : 8'h40) |
				($urandom_range(0, 1) ? 8'h1B : 8'h00);
		endcase
		return b;
	endfunction

	// Lane flags, with junk in the low seven bits of each lane when a random switch is on.
	function automatic logic [blcu_pkg::WORD_W-1:0] make_mask();
		logic [blcu_pkg::WORD_W-1:0] m;
		logic                        junk_on;
		int                          i;
		m       = '0;
		junk_on = 1'($urandom);
		for (i = 0; i < blcu_pkg::MAX_LANES; i++) begin
			m[i*blcu_pkg::LANE_W + 7] = ($urandom_range(0, 2) == 0);
			if (junk_on)
				m[i*blcu_pkg::LANE_W +: 7] = 7'($urandom);
		end
		return m;
	endfunction

	task automatic report_mismatch(string what, logic [blcu_pkg::WORD_W-1:0] got,
			logic [blcu_pkg::WORD_W-1:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Driver: present the next pending word, holding it until it is taken.
	// Random gaps fall between some words, except in the calm tail.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (send_gap > 0) begin
				send_gap   <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				item       <= pending_words.pop_front();
				item_valid <= 1'b1;
				if (pending_words.size() > TAIL_WORDS && $urandom_range(0, 4) == 0)
					send_gap <= $urandom_range(1, 4);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: retire results first, then log the word taken at this edge, so
	// the order of pop and push never depends on the scheduler.
	always @(posedge clk) begin : monitor
		blcu_pkg::blcu_out_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result word", result.result_word, '0);
				end else begin
					want = expected_results.pop_front();
					if (result.result_word !== want.result_word)
						report_mismatch("result_word", result.result_word,
							want.result_word);
					if (result.lane_result !== want.lane_result)
						report_mismatch("lane_result",
							blcu_pkg::WORD_W'(result.lane_result),
							blcu_pkg::WORD_W'(want.lane_result));
				end
			end
			if (item_valid && item_ready) begin
				expected_results.push_back(predict_lanes(item));
				words_taken <= words_taken + 1;
			end
			// Stall the result side in bursts; keep ready high in the calm tail.
			if (recv_stall > 0) begin
				recv_stall   <= recv_stall - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (pending_words.size() > TAIL_WORDS && $urandom_range(0, 4) == 0)
					recv_stall <= $urandom_range(1, 4);
			end
		end
	end

	// Watchdog: end the run when no handshake happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("byte_lane_compare_unit_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		blcu_pkg::blcu_in_t w;
		int                 n, k;

		// Directed words. Bytes at and above 0x80 against the compares first.
		pending_words.push_back(make_item(blcu_pkg::OP_GE,
			64'hC040_FE01_FF80_7F00, '0, 8'h80, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_GE,
			64'hFFFF_FFFF_FFFF_FFFF, '0, 8'h00, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_LE,
			64'hC040_FE01_FF80_7F00, '0, 8'hFF, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_LE,
			64'h8180_7F7E_00FF_8001, '0, 8'h7F, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_SUB7,
			64'h0000_0001_7F80_FFFE, '0, 8'hFF, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_SUB7,
			64'hFFFF_FFFF_8081_7F00, '0, 8'h00, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_ZERO,
			64'h0080_0001_FF00_8000, '0, 8'hFF, 8'hFF, 1'b1, '0));
		// Equality with and without case folding; '@'/'`' and '['/'{' must not fold.
		pending_words.push_back(make_item(blcu_pkg::OP_EQ,
			64'h4060_4161_4261_4161, '0, 8'h61, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_EQ,
			64'h4060_4161_4261_4161, '0, 8'h61, 8'h00, 1'b1, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_EQ,
			64'h5B7B_5B7B_4161_4060, '0, 8'h5B, 8'h00, 1'b1, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_XOR,
			64'hFFFF_FFFF_FFFF_FFFF, '0, 8'h00, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
		pending_words.push_back(make_item(blcu_pkg::OP_XOR,
			64'h7A5A_6141_4060_5B7B, 64'h5A7A_4161_6040_7B5B, 8'h00, 8'h00, 1'b1, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_FAM_EQ,
			64'h0123_4567_89AB_CDEF, '0, 8'h5A, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_FAM_EQ,
			64'h5A5B_DA5A_005A_FF5A, '0, 8'h5A, 8'hFF, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_FAM_EQ,
			64'h5A50_5F4A_D000_F5A0, '0, 8'h5A, 8'hF0, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_UPPER,
			64'h3F40_5F60_C0DF_E04A, '0, 8'h00, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_DIGIT,
			64'h2F30_393F_40B0_FF35, '0, 8'h00, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(blcu_pkg::OP_ALPHA,
			64'h4041_5A5B_6061_7A7B, '0, 8'h00, 8'h00, 1'b0, '0));
		// Mask operations: full, empty, and junk bits outside the flag bit only.
		pending_words.push_back(make_item(blcu_pkg::OP_COUNT, '0, '0, 8'h00, 8'h00, 1'b0,
			64'h8080_8080_8080_8080));
		pending_words.push_back(make_item(blcu_pkg::OP_COUNT, '1, '1, 8'hFF, 8'hFF, 1'b1,
			64'h7F7F_7F7F_7F7F_7F7F));
		pending_words.push_back(make_item(blcu_pkg::OP_LOWIDX, '0, '0, 8'h00, 8'h00, 1'b0,
			'0));
		pending_words.push_back(make_item(blcu_pkg::OP_LOWIDX, '0, '0, 8'h00, 8'h00, 1'b0,
			64'h807F_7F7F_7F7F_7F7F));
		pending_words.push_back(make_item(blcu_pkg::OP_HIGHIDX, '0, '0, 8'h00, 8'h00,
			1'b0, 64'h7F7F_7F7F_7F7F_7F7F));
		pending_words.push_back(make_item(blcu_pkg::OP_HIGHIDX, '0, '0, 8'h00, 8'h00,
			1'b0, 64'h0000_0000_0000_0080));
		pending_words.push_back(make_item(blcu_pkg::OP_LOWER,
			64'h415A_5B40_C1E1_617A, '0, 8'h00, 8'h00, 1'b0, '0));
		pending_words.push_back(make_item(OP_SPARE_LO, '1, '1, 8'hFF, 8'hFF, 1'b1, '1));
		pending_words.push_back(make_item(OP_SPARE_HI, '1, '1, 8'hFF, 8'hFF, 1'b1, '1));

		// Random words: mostly text-like lanes, the rest raw noise.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			w.opcode      = 4'($urandom_range(0, 15));
			w.key_byte    = ($urandom_range(0, 2) == 0) ?
				(8'($urandom_range(8'h41, 8'h5A)) |
					($urandom_range(0, 1) ? blcu_pkg::CASE_BIT : 8'h00))
				: 8'($urandom);
			w.family_bits = 8'($urandom);
			w.ignore_case = 1'($urandom);
			if ($urandom_range(0, 3) == 0) begin
				w.data_word = {$urandom, $urandom};
			end else begin
				for (k = 0; k < blcu_pkg::MAX_LANES; k++)
					w.data_word[k*blcu_pkg::LANE_W +: blcu_pkg::LANE_W] =
						pick_lane_byte(w.key_byte);
			end
			if ($urandom_range(0, 1) == 0) begin
				w.other_word = {$urandom, $urandom};
			end else begin
				// Case twins of the data lanes exercise the folded xor.
				for (k = 0; k < blcu_pkg::MAX_LANES; k++)
					w.other_word[k*blcu_pkg::LANE_W +: blcu_pkg::LANE_W] =
						w.data_word[k*blcu_pkg::LANE_W +: blcu_pkg::LANE_W] ^
						($urandom_range(0, 1) ? blcu_pkg::CASE_BIT : 8'($urandom));
			end
			w.lane_mask = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : make_mask();
			pending_words.push_back(w);
		end
		total_words = pending_words.size();

		// Hold reset at the start, then release it once for the whole run.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken < total_words)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// Allow for a stray result to surface after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("byte_lane_compare_unit_top regression: pass");
		else
			$display("byte_lane_compare_unit_top regression: fail");
		$finish;
	end

endmodule

/* files.f */
hdl/blcu_pkg.sv
hdl/blcu_lane.sv
hdl/blcu_merge.sv
hdl/byte_lane_compare_unit_top.sv
tb/tb.sv
